@@ rtl/tbwc_pkg.sv @@
// shared constants and control types of the token bucket wait calculator
package tbwc_pkg;

  // register fields
  localparam int unsigned CAP_W      = 16;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned FULL_W     = CAP_W + PERIOD_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd1;

  // reset values of the registers
  localparam logic [CAP_W-1:0]    CAPACITY_RST = 16'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd1000;
  localparam logic [FULL_W-1:0]   FULL_RST     = 40'd1000;

  // credit is signed and floored at -2^48
  localparam int unsigned CREDIT_W   = 49;
  // refill time above 2^49 always fills the bucket
  localparam int unsigned ELAPSED_W  = 50;
  localparam int unsigned PROD_W     = ELAPSED_W + CAP_W;
  localparam int unsigned DEBT_W     = 49;
  localparam int unsigned REM_W      = CAP_W;

  // sequencing
  localparam int unsigned MUL_STEPS  = CAP_W;
  localparam int unsigned DIV_STEPS  = DEBT_W;
  localparam int unsigned CNT_W      = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the request beat, start the refill product
    logic mul_step;  // one shift-add step of elapsed times capacity
    logic refill;    // add the product, cap at a full bucket
    logic charge;    // take one period, floor the debt, load the divider
    logic div_step;  // one restoring division step of debt by capacity
    logic out_load;  // round up, clip and load the result register
  } tbwc_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic out_free;  // result register empty or emptied in this cycle
  } tbwc_stat_t;

endpackage

@@ rtl/tbwc_req_if.sv @@
// request channel: one timestamp per beat
interface tbwc_req_if #(
  parameter int unsigned TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink   (input valid, input now_time, output ready);
endinterface

@@ rtl/tbwc_rsp_if.sv @@
// response channel: one wait time and saturation flag per beat
interface tbwc_rsp_if #(
  parameter int unsigned WAIT_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WAIT_BITS-1:0] wait_time;
  logic                 saturated;

  modport source (output valid, output wait_time, output saturated, input ready);
  modport sink   (input valid, input wait_time, input saturated, output ready);
endinterface

@@ rtl/token_bucket_wait_calc.sv @@
// Token bucket rate limiter with debt: each request beat carries a millisecond timestamp and
// yields one beat with the wait in milliseconds (zero when credit stays non-negative, else the
// debt divided by capacity rounded up) and a flag set when the debt floor or the wait ceiling
// clipped it. Credit is kept in units of 1/period_ms of a token: elapsed time refills elapsed
// times bucket_capacity, up to capacity times period, and each request costs period_ms. The
// first request after reset or a register write refills nothing but records the time; a write to either
// register reloads a full bucket. A request passes from acceptance to the result beat through
// 16 shift-add steps for the refill product, the refill and charge updates and 49 restoring division
// steps, one request in flight at a time. The result sits in an output register, so the next
// request may be accepted while the previous beat waits on the response channel.
module token_bucket_wait_calc #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned WAIT_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbwc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tbwc_req_if.sink                        req_i,
  tbwc_rsp_if.source                      rsp_o
);
  import tbwc_pkg::*;

  tbwc_cmd_t  cmd;
  tbwc_stat_t stat;

  // sequencer
  tbwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  tbwc_dp #(
    .TIME_BITS (TIME_BITS),
    .WAIT_BITS (WAIT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .now_time_i  (req_i.now_time),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .wait_time_o (rsp_o.wait_time),
    .saturated_o (rsp_o.saturated)
  );

endmodule

@@ rtl/tbwc_ctrl.sv @@
// sequencer of the token bucket wait calculator
module tbwc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  tbwc_pkg::tbwc_stat_t stat_i,
  output tbwc_pkg::tbwc_cmd_t  cmd_o
);
  import tbwc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_REFILL = 3'd2;
  localparam logic [2:0] S_CHARGE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [CNT_W-1:0] MulLast = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DivLast = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // next state, step counter and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == MulLast) begin
          state_d = S_REFILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = S_CHARGE;
      end
      S_CHARGE: begin
        cmd_o.charge = 1'b1;
        cnt_d        = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivLast) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        // hold until the result register can take the beat
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // an accepted request starts the refill product next cycle
  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MUL && cnt_q == '0))
    else $error("accepted request did not start the multiply");

  // counter stays within the division length
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= DivLast))
    else $error("division step count out of range");

  // a loaded result returns the sequencer to idle
  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

@@ rtl/tbwc_dp.sv @@
// datapath: bucket state, serial multiply, serial divide, result register
module tbwc_dp #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned WAIT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tbwc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tbwc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [TIME_BITS-1:0]               now_time_i,
  input  tbwc_pkg::tbwc_cmd_t                cmd_i,
  output tbwc_pkg::tbwc_stat_t               stat_o,
  input  logic                               rsp_ready_i,
  output logic                               rsp_valid_o,
  output logic [WAIT_BITS-1:0]               wait_time_o,
  output logic                               saturated_o
);
  import tbwc_pkg::*;

  localparam int unsigned EXT_W = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
  localparam logic [ELAPSED_W-1:0] ElapsedMax = ELAPSED_W'(1) << (ELAPSED_W - 1);
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned CHG_W = CREDIT_W + 1;
  localparam logic [CHG_W-1:0] CreditFloor = -(CHG_W'(1) << (CREDIT_W - 1));
  localparam logic [DEBT_W-1:0] WaitMax = DEBT_W'((64'd1 << WAIT_BITS) - 64'd1);

  // configuration and bucket state
  logic [CAP_W-1:0]     capacity_q, capacity_d;
  logic [PERIOD_W-1:0]  period_q, period_d;
  logic [FULL_W-1:0]    full_q;
  logic [CREDIT_W-1:0]  credit_q, credit_d;
  logic                 started_q, started_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic                 cfg_hit;

  // serial units
  logic [PROD_W-1:0]    mcand_q;
  logic [CAP_W-1:0]     mplier_q;
  logic [PROD_W-1:0]    acc_q;
  logic [DEBT_W-1:0]    dvd_q;
  logic [REM_W-1:0]     rem_q;
  logic                 sat_q;

  // result register
  logic                 out_valid_q;
  logic [WAIT_BITS-1:0] wait_q;
  logic                 sat_out_q;

  // request side values
  logic [TIME_BITS-1:0] last_eff;
  logic                 forward;
  logic [TIME_BITS-1:0] elapsed;
  logic [EXT_W-1:0]     elapsed_ext;
  logic [ELAPSED_W-1:0] elapsed_clip;

  // update values
  logic signed [SUM_W-1:0] refill_sum;
  logic signed [SUM_W-1:0] full_ext;
  logic signed [CHG_W-1:0] charged;
  logic                    floor_hit;
  logic [CHG_W-1:0]        credit_chg;
  logic [REM_W:0]          rem_shift;
  logic                    rem_ge;
  logic [DEBT_W-1:0]       wait_full;
  logic                    wait_clip;

  // zero in a register acts as one
  always_comb begin
    capacity_d = capacity_q;
    period_d   = period_q;
    cfg_hit    = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPACITY: begin
          capacity_d = (cfg_wdata_i[CAP_W-1:0] == '0) ? CAP_W'(1) : cfg_wdata_i[CAP_W-1:0];
          cfg_hit    = 1'b1;
        end
        REG_PERIOD: begin
          period_d = (cfg_wdata_i == '0) ? PERIOD_W'(1) : cfg_wdata_i;
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // elapsed time, backwards time refills nothing, clipped where it fills anyway
  always_comb begin
    last_eff     = started_q ? last_q : now_time_i;
    forward      = now_time_i > last_eff;
    elapsed      = forward ? (now_time_i - last_eff) : '0;
    elapsed_ext  = EXT_W'(elapsed);
    elapsed_clip = (elapsed_ext > EXT_W'(ElapsedMax)) ? ElapsedMax
                                                       : elapsed_ext[ELAPSED_W-1:0];
  end

  // refill capped at a full bucket, then charge one period with a floor
  always_comb begin
    refill_sum = $signed({{(SUM_W - CREDIT_W){credit_q[CREDIT_W-1]}}, credit_q})
               + $signed({2'b00, acc_q});
    full_ext   = $signed(SUM_W'(full_q));
    charged    = $signed({credit_q[CREDIT_W-1], credit_q})
               - $signed(CHG_W'(period_q));
    floor_hit  = charged < $signed(CreditFloor);
    credit_chg = floor_hit ? CreditFloor : charged;
  end

  // restoring division step and final rounding
  always_comb begin
    rem_shift = {rem_q, dvd_q[DEBT_W-1]};
    rem_ge    = rem_shift >= (REM_W + 1)'(capacity_q);
    wait_full = dvd_q + DEBT_W'(rem_q != '0);
    wait_clip = wait_full > WaitMax;
  end

  // bucket state updates
  always_comb begin
    credit_d  = credit_q;
    started_d = started_q;
    last_d    = last_q;
    if (cfg_hit) begin
      credit_d  = CREDIT_W'(FULL_W'(capacity_d) * FULL_W'(period_d));
      started_d = 1'b0;
    end else if (cmd_i.accept) begin
      started_d = 1'b1;
      last_d    = forward ? now_time_i : last_eff;
    end else if (cmd_i.refill) begin
      credit_d = (refill_sum > full_ext) ? CREDIT_W'(full_q) : refill_sum[CREDIT_W-1:0];
    end else if (cmd_i.charge) begin
      credit_d = credit_chg[CREDIT_W-1:0];
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAPACITY_RST;
      period_q    <= PERIOD_RST;
      full_q      <= FULL_RST;
      credit_q    <= CREDIT_W'(FULL_RST);
      started_q   <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      capacity_q <= capacity_d;
      period_q   <= period_d;
      if (cfg_hit) begin
        full_q <= FULL_W'(capacity_d) * FULL_W'(period_d);
      end
      credit_q  <= credit_d;
      started_q <= started_d;
      last_q    <= last_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // serial multiply, serial divide and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mcand_q  <= PROD_W'(elapsed_clip);
      mplier_q <= capacity_q;
      acc_q    <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd_i.charge) begin
      sat_q <= floor_hit;
      dvd_q <= credit_chg[CHG_W-1] ? DEBT_W'(-credit_chg) : '0;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DEBT_W-2:0], rem_ge};
      rem_q <= rem_ge ? REM_W'(rem_shift - (REM_W + 1)'(capacity_q)) : rem_shift[REM_W-1:0];
    end
    if (cmd_i.out_load) begin
      wait_q    <= wait_clip ? WaitMax[WAIT_BITS-1:0] : wait_full[WAIT_BITS-1:0];
      sat_out_q <= sat_q || wait_clip;
    end
  end

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o     = out_valid_q;
  assign wait_time_o     = wait_q;
  assign saturated_o     = sat_out_q;

  // credit never exceeds a full bucket
  a_credit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q[CREDIT_W-1] || (credit_q[CREDIT_W-2:0] <= (CREDIT_W - 1)'(full_q)))
    else $error("credit above full bucket");

  // a result is loaded only into a free register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register overwritten");

  // a loaded result is offered in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> rsp_valid_o)
    else $error("loaded result not offered");

endmodule

@@ dv/tbwc_wait_checker.sv @@
// checker for the token bucket wait calculator: predicts each wait beat and compares it
module tbwc_wait_checker
  import tbwc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned WAIT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [TIME_BITS-1:0]  req_now_time_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  logic [WAIT_BITS-1:0]  rsp_wait_time_i,
  input  logic                  rsp_saturated_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           delayed_o,
  output int unsigned           clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint          CREDIT_FLOOR = -longint'(64'd1 << 48);
  localparam longint unsigned WAIT_MAX     = (64'd1 << WAIT_BITS) - 64'd1;

  typedef struct packed {
    logic [WAIT_BITS-1:0] wait_time;
    logic                 saturated;
  } wait_beat_t;

  // mirrored limiter state
  logic [CAP_W-1:0]     capacity;
  logic [PERIOD_W-1:0]  period;
  logic                 started;
  logic [TIME_BITS-1:0] last_stamp;
  longint               credit;

  // waits owed by the block, oldest first
  wait_beat_t owed_waits[$];

  function automatic longint bucket_full();
    return longint'(64'(capacity) * 64'(period));
  endfunction

  // refill by elapsed time, charge one period, turn any debt into a wait
  function automatic wait_beat_t charge_request(input logic [TIME_BITS-1:0] stamp);
    longint unsigned elapsed;
    longint unsigned headroom;
    longint unsigned debt;
    longint unsigned wait_ms;
    wait_beat_t      res;
    res     = '0;
    wait_ms = 64'd0;
    if (!started) begin
      started    = 1'b1;
      last_stamp = stamp;
    end
    elapsed  = (stamp > last_stamp) ? 64'(stamp - last_stamp) : 64'd0;
    headroom = $unsigned(bucket_full() - credit);
    // a refill past the cap just fills the bucket
    if (elapsed > headroom / 64'(capacity)) begin
      credit = bucket_full();
    end else begin
      credit = credit + $signed(elapsed * 64'(capacity));
    end
    if (credit > bucket_full()) begin
      credit = bucket_full();
    end
    // time going backwards keeps the later stamp
    if (stamp > last_stamp) begin
      last_stamp = stamp;
    end
    credit = credit - longint'(64'(period));
    if (credit < CREDIT_FLOOR) begin
      credit        = CREDIT_FLOOR;
      res.saturated = 1'b1;
    end
    // debt over capacity, rounded up, clipped at the ceiling
    if (credit < 0) begin
      debt    = $unsigned(-credit);
      wait_ms = debt / 64'(capacity) + ((debt % 64'(capacity) != 64'd0) ? 64'd1 : 64'd0);
      if (wait_ms > WAIT_MAX) begin
        wait_ms       = WAIT_MAX;
        res.saturated = 1'b1;
      end
    end
    res.wait_time = wait_ms[WAIT_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wait_beat_t due;
    if (!rst_ni) begin
      capacity   = CAPACITY_RST;
      period     = PERIOD_RST;
      started    = 1'b0;
      last_stamp = '0;
      credit     = bucket_full();
      owed_waits.delete();
      errors_o   = 0;
      pending_o  = 0;
      results_o  = 0;
      delayed_o  = 0;
      clipped_o  = 0;
    end else begin
      // register write: zero acts as one, known indexes restart the limiter
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CAPACITY) begin
          capacity = (cfg_wdata_i[CAP_W-1:0] == '0) ? CAP_W'(1) : cfg_wdata_i[CAP_W-1:0];
          started  = 1'b0;
          credit   = bucket_full();
        end else if (cfg_idx_i == REG_PERIOD) begin
          period  = (cfg_wdata_i[PERIOD_W-1:0] == '0) ? PERIOD_W'(1) : cfg_wdata_i[PERIOD_W-1:0];
          started = 1'b0;
          credit  = bucket_full();
        end
      end

      // result beat against the oldest owed wait
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_waits.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result beat, wait_time %0d saturated %0b", $time,
                   rsp_wait_time_i, rsp_saturated_i);
        end else begin
          due = owed_waits.pop_front();
          results_o++;
          if (due.wait_time != '0) delayed_o++;
          if (due.saturated) clipped_o++;
          if (rsp_wait_time_i !== due.wait_time) begin
            errors_o++;
            $display("%0t: wait_time mismatch, expected %0d, actual %0d", $time,
                     due.wait_time, rsp_wait_time_i);
          end
          if (rsp_saturated_i !== due.saturated) begin
            errors_o++;
            $display("%0t: saturated mismatch, expected %0b, actual %0b", $time,
                     due.saturated, rsp_saturated_i);
          end
        end
      end

      // request beat
      if (req_valid_i && req_ready_i) begin
        owed_waits.push_back(charge_request(req_now_time_i));
      end
      pending_o = owed_waits.size();
    end
  end

endmodule

@@ dv/token_bucket_wait_calc_tb.sv @@
// testbench top for the token bucket wait calculator: stimulus, back-pressure and verdict
module token_bucket_wait_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbwc_pkg::*;

  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned WAIT_BITS   = 32;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  tbwc_req_if #(.TIME_BITS(TIME_BITS)) req_if ();
  tbwc_rsp_if #(.WAIT_BITS(WAIT_BITS)) rsp_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned delayed;
  int unsigned clipped;

  // stimulus bookkeeping
  logic [TIME_BITS-1:0] stamp_ms;
  int unsigned          cur_cap = 1;
  int unsigned          cur_per = 1000;
  int unsigned          burst_left = 0;
  int unsigned          sent = 0;
  int unsigned          settings = 1;
  int unsigned          cycles = 0;

  token_bucket_wait_calc #(
    .TIME_BITS (TIME_BITS),
    .WAIT_BITS (WAIT_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  tbwc_wait_checker #(
    .TIME_BITS (TIME_BITS),
    .WAIT_BITS (WAIT_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_now_time_i  (req_if.now_time),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_wait_time_i (rsp_if.wait_time),
    .rsp_saturated_i (rsp_if.saturated),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .delayed_o       (delayed),
    .clipped_o       (clipped)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls: short random flicker, long stalls, and stall-free stretches
  initial begin
    int unsigned run;
    logic        level;
    run   = 0;
    level = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            level = 1'b1;
            run   = $urandom_range(100, 400);
          end
          1: begin
            level = 1'b0;
            run   = $urandom_range(20, 100);
          end
          default: begin
            level = 1'($urandom_range(0, 1));
            run   = $urandom_range(1, 6);
          end
        endcase
      end
      rsp_if.ready <= level;
      run--;
    end
  end

  // one request beat, sent in bursts with random gaps between them
  task automatic send_request(input logic [TIME_BITS-1:0] stamp);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(70, 150);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.now_time <= stamp;
    burst_left--;
    sent++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending and wait for every owed result
  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_bucket(input logic [CFG_DATA_W-1:0] cap_data,
                            input logic [CFG_DATA_W-1:0] per_data);
    settle();
    write_reg(REG_CAPACITY, cap_data);
    write_reg(REG_PERIOD, per_data);
    cur_cap = (cap_data[CAP_W-1:0] == '0) ? 1 : cap_data[CAP_W-1:0];
    cur_per = (per_data[PERIOD_W-1:0] == '0) ? 1 : per_data[PERIOD_W-1:0];
    settings++;
  endtask

  // next timestamp: small forward steps when draining, else mostly forward steps around
  // the break-even pace, plus repeats, backward steps, big jumps and fully random stamps
  task automatic advance_clock(input bit drain);
    int unsigned span;
    int unsigned pick;
    span = 2 * (cur_per / cur_cap) + 2;
    pick = $urandom_range(0, 99);
    if (drain) begin
      stamp_ms = stamp_ms + TIME_BITS'($urandom_range(0, 3));
    end else if (pick < 78) begin
      stamp_ms = stamp_ms + TIME_BITS'($urandom_range(0, span));
    end else if (pick < 86) begin
      stamp_ms = stamp_ms;
    end else if (pick < 93) begin
      stamp_ms = stamp_ms - TIME_BITS'($urandom_range(1, span));
    end else if (pick < 97) begin
      stamp_ms = stamp_ms + TIME_BITS'($urandom());
    end else begin
      stamp_ms = TIME_BITS'({$urandom(), $urandom()});
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cap_data,
                           input logic [CFG_DATA_W-1:0] per_data,
                           input int unsigned count, input bit drain);
    set_bucket(cap_data, per_data);
    stamp_ms = TIME_BITS'({$urandom(), $urandom()});
    repeat (count) begin
      advance_clock(drain);
      send_request(stamp_ms);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] cap_data;
    logic [CFG_DATA_W-1:0] per_data;
    req_if.valid    = 1'b0;
    req_if.now_time = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first request, debt build-up, backward time, extremes
    send_request(48'h0000_0000_0123);
    send_request(48'h0000_0000_0123);
    send_request(48'h0000_0000_0123);
    send_request(48'h0000_0000_0005);
    send_request(48'h0000_0000_0123 + 48'd500);
    send_request(48'hFFFF_FFFF_FFFF);
    send_request(48'h0000_0000_0000);
    send_request(48'hFFFF_FFFF_FFFF);
    send_request(48'hAAAA_AAAA_AAAA);
    send_request(48'h5555_5555_5555);

    // writes to unused indexes leave the limiter running
    settle();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
    send_request(48'h5555_5555_5555);
    send_request(48'h5555_5555_5555);

    // zero writes act as one, capacity bits above its width are dropped
    set_bucket(24'hFF_0000, 24'h00_0000);
    send_request(48'h0);
    send_request(48'h0);
    send_request(48'h0);
    send_request(48'h3);
    send_request(48'h2);

    // full-scale registers
    set_bucket(24'h00_FFFF, 24'hFF_FFFF);
    send_request(48'h0);
    send_request(48'h0);
    send_request(48'h0);
    send_request(48'h10);

    // random phases, one of them driven into the wait ceiling
    run_phase(24'h00_0000, 24'h00_0000, 60, 1'b0);
    run_phase(24'h00_FFFF, 24'hFF_FFFF, 120, 1'b0);
    run_phase(24'h00_0001, 24'hFF_FFFF, 300, 1'b1);
    repeat (5) begin
      cap_data = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom_range(1, 16))
                                             : CFG_DATA_W'($urandom());
      per_data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 100))
                                             : CFG_DATA_W'($urandom());
      run_phase(cap_data, per_data, 80, 1'b0);
    end

    // drain and let any stray beat show up
    settle();
    repeat (80) @(negedge clk_i);

    $display("covered %0d requests over %0d bucket settings, zero and full-scale included",
             sent, settings);
    $display("%0d results checked: %0d delayed, %0d clipped, %0d mismatches",
             results, delayed, clipped, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
